@@ hw/rtl/emr_pkg.sv @@
package emr_pkg;

    localparam int RADIUS_BITS = 9;
    localparam int CENTER_BITS = 10;
    localparam int COORD_BITS  = 12;
    localparam int WALK_BITS   = RADIUS_BITS + 1;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    // operands: squared radius, (2x+1)^2 and (y-1)^2 all fit
    localparam int MUL_BITS    = 2 * WALK_BITS + 4;
    localparam int DEC_BITS    = 2 * MUL_BITS;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic [RADIUS_BITS-1:0]     radius_t;
    typedef logic [CENTER_BITS-1:0]     center_t;
    typedef logic [WALK_BITS-1:0]       walk_t;
    typedef logic [SQ_BITS-1:0]         sq_t;
    typedef logic [MUL_BITS-1:0]        mul_op_t;
    typedef logic [DEC_BITS-1:0]        prod_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;
    typedef logic [COORD_BITS-1:0]      coord_t;

    typedef struct packed {
        logic    command;
        center_t center_x;
        center_t center_y;
        radius_t radius_x;
        radius_t radius_y;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         last;
        logic                         finished;
    } pix_t;

endpackage

@@ hw/rtl/emr_mul.sv @@
module emr_mul (
    input  logic             clk,
    input  emr_pkg::mul_op_t a,
    input  emr_pkg::mul_op_t b,
    output emr_pkg::prod_t   prod
);

    emr_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= emr_pkg::prod_t'(a) * emr_pkg::prod_t'(b);
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/midpoint_ellipse_rasterizer_core.sv @@
// start request: ST_SQX, ST_SQY, ST_INIT_A, ST_INIT_B compute rx^2, ry^2 and d, no pixels
// step request: region two runs ST_UPD_A to ST_UPD_C; region one first runs the region
// test in ST_CHK_A to ST_CHK_C, the switch to region two adds ST_ENT_A to ST_ENT_F; then
// 4 pixels one per cycle while pix_ready is high. one shared 24x24 multiplier with a
// registered product; idle step ignored. reset (async, active low): idle, no walk active
module midpoint_ellipse_rasterizer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  emr_pkg::cmd_t cmd,
    output logic          pix_valid,
    input  logic          pix_ready,
    output emr_pkg::pix_t pix
);

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_SQX    = 19'h00002,
        ST_SQY    = 19'h00004,
        ST_INIT_A = 19'h00008,
        ST_INIT_B = 19'h00010,
        ST_CHK_A  = 19'h00020,
        ST_CHK_B  = 19'h00040,
        ST_CHK_C  = 19'h00080,
        ST_ENT_A  = 19'h00100,
        ST_ENT_B  = 19'h00200,
        ST_ENT_C  = 19'h00400,
        ST_ENT_D  = 19'h00800,
        ST_ENT_E  = 19'h01000,
        ST_ENT_F  = 19'h02000,
        ST_UPD_A  = 19'h04000,
        ST_UPD_B  = 19'h08000,
        ST_UPD_C  = 19'h10000,
        ST_EMIT   = 19'h20000,
        ST_SPARE  = 19'h40000
    } state_t;

    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic   region_two_reg, region_two_next;
    logic [1:0] idx_reg, idx_next;

    emr_pkg::center_t cx_reg, cx_next;
    emr_pkg::center_t cy_reg, cy_next;
    emr_pkg::radius_t rx_reg, rx_next;
    emr_pkg::radius_t ry_reg, ry_next;
    emr_pkg::sq_t     rx2_reg, rx2_next;
    emr_pkg::sq_t     ry2_reg, ry2_next;
    emr_pkg::walk_t   x_reg, x_next;
    emr_pkg::walk_t   y_reg, y_next;
    emr_pkg::dec_t    d_reg, d_next;
    emr_pkg::prod_t   pa_reg, pa_next;
    emr_pkg::mul_op_t tmp_reg, tmp_next;
    logic             xinc_reg, xinc_next;
    logic             ydec_reg, ydec_next;

    emr_pkg::mul_op_t mul_a, mul_b;
    emr_pkg::prod_t   prod;
    emr_pkg::dec_t    prod_s;
    emr_pkg::walk_t   y_dec;
    logic             d_neg;
    logic             d_zero;

    emr_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_s = emr_pkg::dec_t'(prod);
    assign y_dec  = y_reg - emr_pkg::walk_t'(1);
    assign d_neg  = d_reg[emr_pkg::DEC_BITS-1];
    assign d_zero = (d_reg == '0);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = emr_pkg::mul_op_t'(rx_reg);
                mul_b = emr_pkg::mul_op_t'(rx_reg);
            end
            ST_SQY:
            begin
                mul_a = emr_pkg::mul_op_t'(ry_reg);
                mul_b = emr_pkg::mul_op_t'(ry_reg);
            end
            ST_INIT_A:
            begin
                mul_a = emr_pkg::mul_op_t'(rx2_reg);
                mul_b = emr_pkg::mul_op_t'(ry_reg);
            end
            ST_CHK_A, ST_UPD_A:
            begin
                mul_a = emr_pkg::mul_op_t'(ry2_reg);
                mul_b = emr_pkg::mul_op_t'(x_next);
            end
            ST_CHK_B:
            begin
                mul_a = emr_pkg::mul_op_t'(rx2_reg);
                mul_b = emr_pkg::mul_op_t'(y_reg);
            end
            ST_UPD_B:
            begin
                // only used when y steps down
                mul_a = emr_pkg::mul_op_t'(rx2_reg);
                mul_b = emr_pkg::mul_op_t'(y_dec);
            end
            ST_ENT_A:
            begin
                mul_a = emr_pkg::mul_op_t'({x_reg, 1'b1});
                mul_b = emr_pkg::mul_op_t'({x_reg, 1'b1});
            end
            ST_ENT_B:
            begin
                mul_a = emr_pkg::mul_op_t'(y_dec);
                mul_b = emr_pkg::mul_op_t'(y_dec);
            end
            ST_ENT_C:
            begin
                mul_a = emr_pkg::mul_op_t'(ry2_reg);
                mul_b = tmp_reg;
            end
            ST_ENT_D:
            begin
                mul_a = emr_pkg::mul_op_t'(rx2_reg);
                mul_b = tmp_reg;
            end
            ST_ENT_E:
            begin
                mul_a = emr_pkg::mul_op_t'(rx2_reg);
                mul_b = emr_pkg::mul_op_t'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        region_two_next = region_two_reg;
        idx_next        = idx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        rx2_next        = rx2_reg;
        ry2_next        = ry2_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        pa_next         = pa_reg;
        tmp_next        = tmp_reg;
        xinc_next       = xinc_reg;
        ydec_next       = ydec_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid)
                begin
                    if (cmd.command == emr_pkg::CMD_START)
                    begin
                        cx_next         = cmd.center_x;
                        cy_next         = cmd.center_y;
                        rx_next         = cmd.radius_x;
                        ry_next         = cmd.radius_y;
                        x_next          = '0;
                        y_next          = emr_pkg::walk_t'(cmd.radius_y);
                        region_two_next = 1'b0;
                        active_next     = (cmd.radius_x != '0) && (cmd.radius_y != '0);
                        state_next      = ST_SQX;
                    end
                    else if (active_reg)
                    begin
                        state_next = region_two_reg ? ST_UPD_A : ST_CHK_A;
                    end
                end
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                rx2_next   = emr_pkg::sq_t'(prod);
                state_next = ST_INIT_A;
            end
            ST_INIT_A:
            begin
                ry2_next   = emr_pkg::sq_t'(prod);
                state_next = ST_INIT_B;
            end
            ST_INIT_B:
            begin
                // 4*ry^2 - 4*rx^2*ry + rx^2
                d_next = emr_pkg::dec_t'({ry2_reg, 2'b00}) - (prod_s <<< 2)
                    + emr_pkg::dec_t'(rx2_reg);
                state_next = ST_IDLE;
            end
            ST_CHK_A:
            begin
                state_next = ST_CHK_B;
            end
            ST_CHK_B:
            begin
                pa_next    = prod;
                state_next = ST_CHK_C;
            end
            ST_CHK_C:
            begin
                // leave region one once ry^2*x > rx^2*y
                if (pa_reg > prod)
                begin
                    region_two_next = 1'b1;
                    state_next      = ST_ENT_A;
                end
                else
                begin
                    state_next = ST_UPD_A;
                end
            end
            ST_ENT_A:
            begin
                state_next = ST_ENT_B;
            end
            ST_ENT_B:
            begin
                tmp_next   = emr_pkg::mul_op_t'(prod);
                state_next = ST_ENT_C;
            end
            ST_ENT_C:
            begin
                tmp_next   = emr_pkg::mul_op_t'(prod);
                state_next = ST_ENT_D;
            end
            ST_ENT_D:
            begin
                d_next     = prod_s;
                state_next = ST_ENT_E;
            end
            ST_ENT_E:
            begin
                d_next     = d_reg + (prod_s <<< 2);
                state_next = ST_ENT_F;
            end
            ST_ENT_F:
            begin
                d_next     = d_reg - (prod_s <<< 2);
                state_next = ST_UPD_A;
            end
            ST_UPD_A:
            begin
                if (region_two_reg && (y_reg == '0))
                begin
                    active_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if (!region_two_reg)
                    begin
                        xinc_next = 1'b1;
                        ydec_next = !d_neg;
                    end
                    else
                    begin
                        xinc_next = d_neg || d_zero;
                        ydec_next = 1'b1;
                    end
                    x_next     = xinc_next ? x_reg + emr_pkg::walk_t'(1) : x_reg;
                    state_next = ST_UPD_B;
                end
            end
            ST_UPD_B:
            begin
                // product is ry^2 times the new x
                if (ydec_reg)
                begin
                    y_next = y_dec;
                end
                d_next = d_reg
                    + (xinc_reg ? (prod_s <<< 3) : emr_pkg::dec_t'(0))
                    + (region_two_reg ? emr_pkg::dec_t'({rx2_reg, 2'b00})
                                      : emr_pkg::dec_t'({ry2_reg, 2'b00}));
                state_next = ST_UPD_C;
            end
            ST_UPD_C:
            begin
                // product is rx^2 times the new y
                if (ydec_reg)
                begin
                    d_next = d_reg - (prod_s <<< 3);
                end
                if (y_reg == '0)
                begin
                    active_next = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (pix_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            region_two_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            region_two_reg <= region_two_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        d_reg    <= d_next;
        pa_reg   <= pa_next;
        tmp_reg  <= tmp_next;
        xinc_reg <= xinc_next;
        ydec_reg <= ydec_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pix_valid = (state_reg == ST_EMIT);

    // quadrant order: (+x,+y) (+x,-y) (-x,+y) (-x,-y)
    always_comb
    begin
        if (idx_reg[1])
        begin
            pix.pixel_x = emr_pkg::coord_t'(cx_reg) - emr_pkg::coord_t'(x_reg);
        end
        else
        begin
            pix.pixel_x = emr_pkg::coord_t'(cx_reg) + emr_pkg::coord_t'(x_reg);
        end
        if (idx_reg[0])
        begin
            pix.pixel_y = emr_pkg::coord_t'(cy_reg) - emr_pkg::coord_t'(y_reg);
        end
        else
        begin
            pix.pixel_y = emr_pkg::coord_t'(cy_reg) + emr_pkg::coord_t'(y_reg);
        end
        pix.last     = (idx_reg == 2'd3);
        pix.finished = (idx_reg == 2'd3) && (y_reg == '0);
    end

endmodule
